/* design/sdas_pkg.sv */
`timescale 1ns / 1ps
package sdas_pkg;

  // Operand capacity in digits
  localparam int MAX_DIGITS = 1024;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  // Operand length, and digit position within a result store (MAX_DIGITS+1 entries)
  localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
  // Result length, up to MAX_DIGITS+1
  localparam int SLEN_W     = $clog2(MAX_DIGITS + 2);
  // Read pointer over both results
  localparam int PTR_W      = $clog2(2 * MAX_DIGITS + 3);

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // Request codes
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic clear;
    logic issue_read;
    logic flag_error;
    logic init_pass;
    logic cmp_step;
    logic ari_step;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic a_empty;
    logic b_empty;
    logic computed;
    logic k_last;
  } status_t;

endpackage

/* design/signed_decimal_add_subtract.sv */
`timescale 1ns / 1ps
// Signed decimal add/subtract.
// Requests enter on start/opcode/digit/negative and are taken on a clock edge
// with start high and busy low. Loads (A or B digit, most significant first)
// and clear are taken every cycle while busy is low and give no result, except a load past
// capacity, which gives an error transaction in the next cycle.
// A read returns one digit of A+B, then of A-B, as a transaction on done for
// exactly one cycle; the receiver cannot stall, so it must take each one.
// When results are current a read gives its digit the cycle after it is taken
// and the next read may follow at once. The first read after any load or
// clear holds busy high while the compare pass and the carry/borrow pass walk
// the digits, each position in both passes taking a registered operand store
// read and then a step that uses it, before the digit appears. A read with an
// operand empty gives an error transaction. Reset clears lengths, signs and
// the result state; the digit stores need no clearing.
module signed_decimal_add_subtract (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [3:0] digit,
  input  logic       negative,
  output logic       done,
  output logic       which_result,
  output logic       result_negative,
  output logic [3:0] result_digit,
  output logic       last_digit,
  output logic       all_done,
  output logic       error
);
  import sdas_pkg::*;

  cmd_t    cmd;
  status_t status;

  sdas_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sdas_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .digit           (digit),
    .negative        (negative),
    .status          (status),
    .done            (done),
    .which_result    (which_result),
    .result_negative (result_negative),
    .result_digit    (result_digit),
    .last_digit      (last_digit),
    .all_done        (all_done),
    .error           (error)
  );

endmodule

/* design/sdas_ctrl.sv */
`timescale 1ns / 1ps
module sdas_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       opcode,
  input  sdas_pkg::status_t status,
  output sdas_pkg::cmd_t   cmd,
  output logic             busy
);
  import sdas_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMP_A = 3'd1;
  localparam logic [2:0] ST_CMP_D = 3'd2;
  localparam logic [2:0] ST_ARI_A = 3'd3;
  localparam logic [2:0] ST_ARI_D = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_READ  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Sequencing of requests and the compute passes
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_LOAD_A: cmd.load_a = 1'b1;
            OP_LOAD_B: cmd.load_b = 1'b1;
            OP_CLEAR:  cmd.clear  = 1'b1;
            OP_READ: begin
              if (status.a_empty || status.b_empty) begin
                cmd.flag_error = 1'b1;
              end else if (status.computed) begin
                cmd.issue_read = 1'b1;
              end else begin
                cmd.init_pass = 1'b1;
                state_next    = ST_CMP_A;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CMP_A: state_next = ST_CMP_D;
      ST_CMP_D: begin
        cmd.cmp_step = 1'b1;
        if (status.k_last) begin
          cmd.init_pass = 1'b1;
          state_next    = ST_ARI_A;
        end else begin
          state_next = ST_CMP_A;
        end
      end
      ST_ARI_A: state_next = ST_ARI_D;
      ST_ARI_D: begin
        cmd.ari_step = 1'b1;
        state_next   = status.k_last ? ST_FIN : ST_ARI_A;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.issue_read = 1'b1;
        state_next     = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_a, cmd.load_b, cmd.clear, cmd.issue_read, cmd.flag_error}))
    else $error("more than one request decoded");
  a_read_after_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> cmd.issue_read)
    else $error("finished pass not followed by a read");
  a_read_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_IDLE))
    else $error("read state did not return to idle");

endmodule

/* design/sdas_datapath.sv */
`timescale 1ns / 1ps
module sdas_datapath (
  input  logic              clk,
  input  logic              rst,
  input  sdas_pkg::cmd_t    cmd,
  input  logic [3:0]        digit,
  input  logic              negative,
  output sdas_pkg::status_t status,
  output logic              done,
  output logic              which_result,
  output logic              result_negative,
  output logic [3:0]        result_digit,
  output logic              last_digit,
  output logic              all_done,
  output logic              error
);
  import sdas_pkg::*;

  logic [3:0] a_mem [0:MAX_DIGITS-1];
  logic [3:0] b_mem [0:MAX_DIGITS-1];
  logic [3:0] sum_mem  [0:MAX_DIGITS];
  logic [3:0] diff_mem [0:MAX_DIGITS];

  logic [LEN_W-1:0]  a_len, b_len, n_len, k;
  logic              a_sign, b_sign, computed;
  logic [PTR_W-1:0]  ptr;
  logic [3:0]        a_q, b_q, sum_q, diff_q;
  logic              a_in, b_in;
  logic              b_gt, carry, borrow;
  logic              sum_nz, diff_nz, sum_raw_neg, diff_raw_neg;
  logic [LEN_W-1:0]  sum_hi, diff_hi;
  logic              done_q, err_q, which_q, neg_q, last_q, all_q;

  logic [3:0]        d_clamp, da, db, x, y, addv, subv, sum_v, diff_v, top_v;
  logic [4:0]        s5, y5;
  logic              add_c, sub_b, same_sign, a_big, a_full, b_full;
  logic [SLEN_W-1:0] sum_len, diff_len;
  logic [PTR_W-1:0]  sum_len_p, total, ptr_inc;
  logic [PTR_W-1:0]  saddr_p, daddr_p;
  logic              in_sum, load_err;

  assign d_clamp   = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
  assign a_full    = (a_len == LEN_W'(MAX_DIGITS));
  assign b_full    = (b_len == LEN_W'(MAX_DIGITS));
  assign n_len     = (a_len > b_len) ? a_len : b_len;
  assign same_sign = (a_sign == b_sign);
  assign a_big     = !b_gt;
  assign load_err  = (cmd.load_a && a_full) || (cmd.load_b && b_full);

  assign status.a_empty  = (a_len == '0);
  assign status.b_empty  = (b_len == '0);
  assign status.computed = computed;
  assign status.k_last   = (k == n_len - LEN_W'(1));

  // Operand digit stores, loaded in order, read at weight k
  always_ff @(posedge clk) begin
    if (cmd.load_a && !a_full) a_mem[a_len[ADDR_W-1:0]] <= d_clamp;
    if (cmd.load_b && !b_full) b_mem[b_len[ADDR_W-1:0]] <= d_clamp;
    a_q  <= a_mem[ADDR_W'(a_len - LEN_W'(1) - k)];
    b_q  <= b_mem[ADDR_W'(b_len - LEN_W'(1) - k)];
    a_in <= (k < a_len);
    b_in <= (k < b_len);
  end

  assign da = a_in ? a_q : 4'd0;
  assign db = b_in ? b_q : 4'd0;

  // One decimal digit of add and of subtract
  always_comb begin
    s5    = {1'b0, da} + {1'b0, db} + {4'd0, carry};
    add_c = (s5 > 5'd9);
    addv  = add_c ? 4'(s5 - 5'd10) : s5[3:0];
    x     = a_big ? da : db;
    y     = a_big ? db : da;
    y5    = {1'b0, y} + {4'd0, borrow};
    sub_b = ({1'b0, x} < y5);
    subv  = sub_b ? 4'({1'b0, x} + 5'd10 - y5) : 4'({1'b0, x} - y5);
    sum_v  = same_sign ? addv : subv;
    diff_v = same_sign ? subv : addv;
    top_v  = {3'd0, carry};
  end

  // Result stores, least significant first
  always_ff @(posedge clk) begin
    if (cmd.ari_step) begin
      sum_mem[k]  <= sum_v;
      diff_mem[k] <= diff_v;
    end else if (cmd.finish) begin
      sum_mem[k]  <= same_sign ? top_v : 4'd0;
      diff_mem[k] <= same_sign ? 4'd0 : top_v;
    end
    if (cmd.issue_read) begin
      sum_q  <= sum_mem[saddr_p[LEN_W-1:0]];
      diff_q <= diff_mem[daddr_p[LEN_W-1:0]];
    end
  end

  // Read addressing over sum then difference
  always_comb begin
    sum_len   = sum_nz  ? SLEN_W'({1'b0, sum_hi} + 1'b1)  : SLEN_W'(1);
    diff_len  = diff_nz ? SLEN_W'({1'b0, diff_hi} + 1'b1) : SLEN_W'(1);
    sum_len_p = PTR_W'(sum_len);
    total     = sum_len_p + PTR_W'(diff_len);
    ptr_inc   = ptr + PTR_W'(1);
    in_sum    = (ptr < sum_len_p);
    saddr_p   = sum_len_p - PTR_W'(1) - ptr;
    daddr_p   = PTR_W'(diff_len) - PTR_W'(1) - (ptr - sum_len_p);
  end

  // Operand lengths, signs, pass counters and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      a_len <= '0; b_len <= '0; a_sign <= 1'b0; b_sign <= 1'b0;
      computed <= 1'b0; ptr <= '0; k <= '0;
    end else begin
      if (cmd.load_a) begin
        a_sign <= negative; computed <= 1'b0; ptr <= '0;
        if (!a_full) a_len <= a_len + LEN_W'(1);
      end
      if (cmd.load_b) begin
        b_sign <= negative; computed <= 1'b0; ptr <= '0;
        if (!b_full) b_len <= b_len + LEN_W'(1);
      end
      if (cmd.clear) begin
        a_len <= '0; b_len <= '0; a_sign <= 1'b0; b_sign <= 1'b0;
        computed <= 1'b0; ptr <= '0;
      end
      if (cmd.init_pass) begin
        k <= '0;
      end else if (cmd.cmp_step || cmd.ari_step) begin
        k <= k + LEN_W'(1);
      end
      if (cmd.finish) begin
        computed <= 1'b1; ptr <= '0;
      end
      if (cmd.issue_read) begin
        ptr <= (ptr_inc == total) ? '0 : ptr_inc;
      end
    end
  end

  // Compare, carry, borrow and leading-zero tracking
  always_ff @(posedge clk) begin
    if (cmd.init_pass) begin
      carry <= 1'b0; borrow <= 1'b0;
      sum_nz <= 1'b0; diff_nz <= 1'b0;
    end
    if (cmd.init_pass && !cmd.cmp_step) b_gt <= 1'b0;
    if (cmd.cmp_step && da != db) b_gt <= (da < db);
    if (cmd.ari_step) begin
      carry  <= add_c;
      borrow <= sub_b;
      if (sum_v != 4'd0) begin sum_nz <= 1'b1; sum_hi <= k; end
      if (diff_v != 4'd0) begin diff_nz <= 1'b1; diff_hi <= k; end
    end
    if (cmd.finish) begin
      if (carry) begin
        if (same_sign) begin sum_nz <= 1'b1; sum_hi <= k; end
        else begin diff_nz <= 1'b1; diff_hi <= k; end
      end
      sum_raw_neg  <= same_sign ? a_sign : (a_big ? a_sign : b_sign);
      diff_raw_neg <= same_sign ? (a_big ? a_sign : !b_sign) : a_sign;
    end
  end

  // Result transaction registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd.issue_read || cmd.flag_error || load_err;
    end
    if (cmd.issue_read) begin
      err_q   <= 1'b0;
      which_q <= !in_sum;
      neg_q   <= in_sum ? (sum_nz && sum_raw_neg) : (diff_nz && diff_raw_neg);
      last_q  <= in_sum ? (ptr_inc == sum_len_p) : (ptr_inc == total);
      all_q   <= !in_sum && (ptr_inc == total);
    end else if (cmd.flag_error || load_err) begin
      err_q <= 1'b1; which_q <= 1'b0; neg_q <= 1'b0; last_q <= 1'b0; all_q <= 1'b0;
    end
  end

  assign done            = done_q;
  assign error           = err_q;
  assign which_result    = which_q;
  assign result_negative = neg_q;
  assign last_digit      = last_q;
  assign all_done        = all_q;
  assign result_digit    = err_q ? 4'd0 : (which_q ? diff_q : sum_q);

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (result_digit == 4'd0 && !last_digit && !all_done))
    else $error("error transaction carries data");
  a_all_last: assert property (@(posedge clk) disable iff (rst)
    (done && all_done) |-> (last_digit && which_result))
    else $error("all_done without final difference digit");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    computed |-> (ptr < total))
    else $error("read pointer out of range");

endmodule
